// ===== hw/rtl/sit_pkg.sv =====
// Shared types, index tables and helpers for the segment intersection pipeline.
package sit_pkg;

    // Difference vectors formed in the front stage
    localparam int N_VEC    = 6;
    localparam int V_AS_BS  = 0;  // A start - B start
    localparam int V_BD     = 1;  // B end   - B start
    localparam int V_AE_BS  = 2;  // A end   - B start
    localparam int V_BS_AS  = 3;  // B start - A start
    localparam int V_AD     = 4;  // A end   - A start
    localparam int V_BE_AS  = 5;  // B end   - A start

    // Cross products cross(u, v) = u.x * v.y - u.y * v.x
    localparam int N_CROSS  = 4;
    localparam int X_D1     = 0;
    localparam int X_D2     = 1;
    localparam int X_E1     = 2;
    localparam int X_E2     = 3;

    localparam int U_IDX [N_CROSS] = '{V_AS_BS, V_BD,    V_BS_AS, V_AD};
    localparam int V_IDX [N_CROSS] = '{V_BD,    V_AE_BS, V_AD,    V_BE_AS};

    // Sign of one cross product
    typedef struct packed {
        logic neg;
        logic zero;
    } t_sign;

    // True when the product of the two signs is not negative
    function automatic logic sign_prod_ok(input t_sign a, input t_sign b);
        logic a_pos;
        logic b_pos;
        a_pos = !a.neg && !a.zero;
        b_pos = !b.neg && !b.zero;
        return !((a_pos && b.neg) || (a.neg && b_pos));
    endfunction

endpackage

// ===== hw/rtl/sit_front.sv =====
// Stage 1: endpoint differences and bounding box overlap test.
module sit_front
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_a_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_a_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_end_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH:0]   o_dx [N_VEC],
    output logic signed [COORD_WIDTH:0]   o_dy [N_VEC],
    output logic                          o_box
);

    localparam int CW = COORD_WIDTH;

    logic signed [CW:0] n_dx [N_VEC];
    logic signed [CW:0] n_dy [N_VEC];
    logic signed [CW:0] r_dx [N_VEC];
    logic signed [CW:0] r_dy [N_VEC];
    logic               n_box;
    logic               r_box;
    logic               r_valid;

    logic signed [CW:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic signed [CW-1:0] a_max_x, a_min_x, a_max_y, a_min_y;
    logic signed [CW-1:0] b_max_x, b_min_x, b_max_y, b_min_y;

    // Sign-extend endpoints by one bit for exact differences
    assign ax0 = {i_a_start_x[CW-1], i_a_start_x};
    assign ay0 = {i_a_start_y[CW-1], i_a_start_y};
    assign ax1 = {i_a_end_x[CW-1],   i_a_end_x};
    assign ay1 = {i_a_end_y[CW-1],   i_a_end_y};
    assign bx0 = {i_b_start_x[CW-1], i_b_start_x};
    assign by0 = {i_b_start_y[CW-1], i_b_start_y};
    assign bx1 = {i_b_end_x[CW-1],   i_b_end_x};
    assign by1 = {i_b_end_y[CW-1],   i_b_end_y};

    // Form the six difference vectors
    always_comb begin
        n_dx[V_AS_BS] = ax0 - bx0;
        n_dy[V_AS_BS] = ay0 - by0;
        n_dx[V_BD]    = bx1 - bx0;
        n_dy[V_BD]    = by1 - by0;
        n_dx[V_AE_BS] = ax1 - bx0;
        n_dy[V_AE_BS] = ay1 - by0;
        n_dx[V_BS_AS] = bx0 - ax0;
        n_dy[V_BS_AS] = by0 - ay0;
        n_dx[V_AD]    = ax1 - ax0;
        n_dy[V_AD]    = ay1 - ay0;
        n_dx[V_BE_AS] = bx1 - ax0;
        n_dy[V_BE_AS] = by1 - ay0;
    end

    // Bounding boxes, inclusive overlap on both axes
    always_comb begin
        a_max_x = (i_a_start_x > i_a_end_x) ? i_a_start_x : i_a_end_x;
        a_min_x = (i_a_start_x > i_a_end_x) ? i_a_end_x   : i_a_start_x;
        a_max_y = (i_a_start_y > i_a_end_y) ? i_a_start_y : i_a_end_y;
        a_min_y = (i_a_start_y > i_a_end_y) ? i_a_end_y   : i_a_start_y;
        b_max_x = (i_b_start_x > i_b_end_x) ? i_b_start_x : i_b_end_x;
        b_min_x = (i_b_start_x > i_b_end_x) ? i_b_end_x   : i_b_start_x;
        b_max_y = (i_b_start_y > i_b_end_y) ? i_b_start_y : i_b_end_y;
        b_min_y = (i_b_start_y > i_b_end_y) ? i_b_end_y   : i_b_start_y;
        n_box   = !(a_max_x < b_min_x) && !(b_max_x < a_min_x)
               && !(a_max_y < b_min_y) && !(b_max_y < a_min_y);
    end

    assign o_ready = !r_valid || i_ready;

    // Advance the stage valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load payload on an accepted beat
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_box <= n_box;
        end
    end

    assign o_valid = r_valid;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_box   = r_box;

endmodule

// ===== hw/rtl/sit_prod.sv =====
// Stage 2: the eight partial products of the four cross products.
module sit_prod
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [COORD_WIDTH:0]     i_dx [N_VEC],
    input  logic signed [COORD_WIDTH:0]     i_dy [N_VEC],
    input  logic                            i_box,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [2*COORD_WIDTH+1:0] o_p [N_CROSS],
    output logic signed [2*COORD_WIDTH+1:0] o_q [N_CROSS],
    output logic                            o_box
);

    localparam int PW = 2 * COORD_WIDTH + 2;

    logic signed [PW-1:0] n_p [N_CROSS];
    logic signed [PW-1:0] n_q [N_CROSS];
    logic signed [PW-1:0] r_p [N_CROSS];
    logic signed [PW-1:0] r_q [N_CROSS];
    logic                 r_box;
    logic                 r_valid;

    // Multiply u.x * v.y and u.y * v.x for each cross product
    always_comb begin
        for (int k = 0; k < N_CROSS; k++) begin
            n_p[k] = PW'(i_dx[U_IDX[k]]) * PW'(i_dy[V_IDX[k]]);
            n_q[k] = PW'(i_dy[U_IDX[k]]) * PW'(i_dx[V_IDX[k]]);
        end
    end

    assign o_ready = !r_valid || i_ready;

    // Advance the stage valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load payload on an accepted beat
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_p   <= n_p;
            r_q   <= n_q;
            r_box <= i_box;
        end
    end

    assign o_valid = r_valid;
    assign o_p     = r_p;
    assign o_q     = r_q;
    assign o_box   = r_box;

endmodule

// ===== hw/rtl/sit_sign.sv =====
// Stage 3: sign of each cross product by exact product comparison.
module sit_sign
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [2*COORD_WIDTH+1:0] i_p [N_CROSS],
    input  logic signed [2*COORD_WIDTH+1:0] i_q [N_CROSS],
    input  logic                            i_box,
    output logic                            o_valid,
    input  logic                            i_ready,
    output t_sign                           o_sign [N_CROSS],
    output logic                            o_box
);

    t_sign n_sign [N_CROSS];
    t_sign r_sign [N_CROSS];
    logic  r_box;
    logic  r_valid;

    // Compare the two products instead of forming the difference
    always_comb begin
        for (int k = 0; k < N_CROSS; k++) begin
            n_sign[k].neg  = i_p[k] < i_q[k];
            n_sign[k].zero = i_p[k] == i_q[k];
        end
    end

    assign o_ready = !r_valid || i_ready;

    // Advance the stage valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load payload on an accepted beat
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sign <= n_sign;
            r_box  <= i_box;
        end
    end

    assign o_valid = r_valid;
    assign o_sign  = r_sign;
    assign o_box   = r_box;

    // A product difference is never both negative and zero
    a_sign_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_sign[X_D1].neg && r_sign[X_D1].zero)
                 && !(r_sign[X_D2].neg && r_sign[X_D2].zero)
                 && !(r_sign[X_E1].neg && r_sign[X_E1].zero)
                 && !(r_sign[X_E2].neg && r_sign[X_E2].zero))
        else $error("cross sign flags both set");

endmodule

// ===== hw/rtl/sit_decide.sv =====
// Stage 4: straddle decision and the output register.
module sit_decide
    import sit_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_sign i_sign [N_CROSS],
    input  logic  i_box,
    output logic  o_valid,
    input  logic  i_ready,
    output logic  o_intersects
);

    logic n_hit;
    logic r_hit;
    logic r_valid;

    // Both pairs must not straddle with opposite signs, boxes must meet
    assign n_hit = i_box
                && sign_prod_ok(i_sign[X_D1], i_sign[X_D2])
                && sign_prod_ok(i_sign[X_E1], i_sign[X_E2]);

    assign o_ready = !r_valid || i_ready;

    // Advance the output valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load the flag on an accepted beat
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_hit <= n_hit;
        end
    end

    assign o_valid      = r_valid;
    assign o_intersects = r_hit;

endmodule

// ===== hw/rtl/segment_intersection_test.sv =====
// Top level: four-stage segment intersection test pipeline.
// Each accepted input beat passes the front, product, sign and decide registers.
// Throughput: one segment pair per cycle while i_ready is high; each stage
//   holds its beat while the next is full and stalled; any bubble is absorbed.
// Critical path: the (COORD_WIDTH+1)-bit multipliers of stage 2.
// Reset: synchronous, active low; clears every stage valid bit, payload kept.
module segment_intersection_test
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_a_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_a_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_end_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_intersects
);

    logic signed [COORD_WIDTH:0]     s1_dx [N_VEC];
    logic signed [COORD_WIDTH:0]     s1_dy [N_VEC];
    logic                            s1_box, s1_valid, s1_ready;
    logic signed [2*COORD_WIDTH+1:0] s2_p [N_CROSS];
    logic signed [2*COORD_WIDTH+1:0] s2_q [N_CROSS];
    logic                            s2_box, s2_valid, s2_ready;
    t_sign                           s3_sign [N_CROSS];
    logic                            s3_box, s3_valid, s3_ready;

    // Differences and box test
    sit_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_a_start_x (i_a_start_x),
        .i_a_start_y (i_a_start_y),
        .i_a_end_x   (i_a_end_x),
        .i_a_end_y   (i_a_end_y),
        .i_b_start_x (i_b_start_x),
        .i_b_start_y (i_b_start_y),
        .i_b_end_x   (i_b_end_x),
        .i_b_end_y   (i_b_end_y),
        .o_valid     (s1_valid),
        .i_ready     (s1_ready),
        .o_dx        (s1_dx),
        .o_dy        (s1_dy),
        .o_box       (s1_box)
    );

    // Partial products
    sit_prod #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_dx    (s1_dx),
        .i_dy    (s1_dy),
        .i_box   (s1_box),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_p     (s2_p),
        .o_q     (s2_q),
        .o_box   (s2_box)
    );

    // Cross product signs
    sit_sign #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sign (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_p     (s2_p),
        .i_q     (s2_q),
        .i_box   (s2_box),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_sign  (s3_sign),
        .o_box   (s3_box)
    );

    // Final decision and output register
    sit_decide u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s3_valid),
        .o_ready      (s3_ready),
        .i_sign       (s3_sign),
        .i_box        (s3_box),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_intersects (o_intersects)
    );

    // An accepted beat lands in the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> s1_valid)
        else $error("accepted beat lost at stage 1");

    // Input back-pressure only when the first stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> s1_valid)
        else $error("input stalled with empty stage 1");

    // A result appears only from a beat held in stage 3
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(s3_valid))
        else $error("result without a stage 3 beat");

    // A beat in stage 2 stays until stage 3 can take it
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_valid && !s2_ready |=> s2_valid && s3_valid)
        else $error("stage 2 beat dropped under stall");

endmodule

// ===== tb/segment_intersection_test_tb.sv =====
// Self-checking testbench for the segment intersection test pipeline.
`timescale 1ns / 100ps

module segment_intersection_test_tb;

    localparam int COORD_W      = 16;
    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 3;
    localparam int RANDOM_PAIRS = 540;
    localparam int HOLD_AFTER   = 150;   // input beats before the long receiver hold
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;    // pipeline is 4 deep; leave a margin
    localparam int IDLE_LIMIT   = 2000;  // cycles with no beat on either side
    localparam int REPORT_MAX   = 10;

    typedef logic signed [COORD_W-1:0] coord_t;

    // One segment pair: A start/end, B start/end
    typedef struct {
        coord_t a_sx, a_sy, a_ex, a_ey;
        coord_t b_sx, b_sy, b_ex, b_ey;
    } seg_pair_t;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_ready;
    coord_t i_a_start_x = '0;
    coord_t i_a_start_y = '0;
    coord_t i_a_end_x   = '0;
    coord_t i_a_end_y   = '0;
    coord_t i_b_start_x = '0;
    coord_t i_b_start_y = '0;
    coord_t i_b_end_x   = '0;
    coord_t i_b_end_y   = '0;
    logic   o_valid;
    logic   i_ready = 1'b0;
    logic   o_intersects;

    seg_pair_t pending_pairs[$];
    logic      hit_expected_q[$];
    seg_pair_t cur_pair;
    int        tx_gap_left   = 0;
    int        tx_quiet_left = 0;
    int        rx_stall_left = 0;
    int        rx_quiet_left = 0;
    int        pairs_sent    = 0;
    int        mismatch_cnt  = 0;
    int        idle_cycles   = 0;
    int        hold_left     = 0;
    logic      rx_hold       = 1'b0;
    logic      hold_done     = 1'b0;
    logic      tx_busy;

    segment_intersection_test #(
        .COORD_WIDTH (COORD_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_a_start_x  (i_a_start_x),
        .i_a_start_y  (i_a_start_y),
        .i_a_end_x    (i_a_end_x),
        .i_a_end_y    (i_a_end_y),
        .i_b_start_x  (i_b_start_x),
        .i_b_start_y  (i_b_start_y),
        .i_b_end_x    (i_b_end_x),
        .i_b_end_y    (i_b_end_y),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_intersects (o_intersects)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Sign of u x v; products stay well inside 64 bits at these widths
    function automatic int cross_sign(longint ux, longint uy, longint vx, longint vy);
        longint c;
        c = ux * vy - uy * vx;
        return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
    endfunction

    // Expected flag: inclusive bounding-box overlap, then the straddle test
    function automatic logic seg_pair_hit(seg_pair_t p);
        longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        int d1, d2, e1, e2;
        ax0 = p.a_sx; ay0 = p.a_sy; ax1 = p.a_ex; ay1 = p.a_ey;
        bx0 = p.b_sx; by0 = p.b_sy; bx1 = p.b_ex; by1 = p.b_ey;
        if (((ax0 > ax1) ? ax0 : ax1) < ((bx0 < bx1) ? bx0 : bx1)) return 1'b0;
        if (((bx0 > bx1) ? bx0 : bx1) < ((ax0 < ax1) ? ax0 : ax1)) return 1'b0;
        if (((ay0 > ay1) ? ay0 : ay1) < ((by0 < by1) ? by0 : by1)) return 1'b0;
        if (((by0 > by1) ? by0 : by1) < ((ay0 < ay1) ? ay0 : ay1)) return 1'b0;
        d1 = cross_sign(ax0 - bx0, ay0 - by0, bx1 - bx0, by1 - by0);
        d2 = cross_sign(bx1 - bx0, by1 - by0, ax1 - bx0, ay1 - by0);
        e1 = cross_sign(bx0 - ax0, by0 - ay0, ax1 - ax0, ay1 - ay0);
        e2 = cross_sign(ax1 - ax0, ay1 - ay0, bx1 - ax0, by1 - ay0);
        return (d1 * d2 >= 0) && (e1 * e2 >= 0);
    endfunction

    // Idle length: mostly none or short, a few long, with quiet stretches of none
    function automatic int draw_gap(inout int quiet_left);
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            quiet_left = $urandom_range(30, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_pair(int ax0, int ay0, int ax1, int ay1,
                            int bx0, int by0, int bx1, int by1);
        seg_pair_t p;
        p.a_sx = coord_t'(ax0); p.a_sy = coord_t'(ay0);
        p.a_ex = coord_t'(ax1); p.a_ey = coord_t'(ay1);
        p.b_sx = coord_t'(bx0); p.b_sy = coord_t'(by0);
        p.b_ex = coord_t'(bx1); p.b_ey = coord_t'(by1);
        pending_pairs.push_back(p);
    endtask

    // Coordinate of a given flavor: full range, small, or picked from the extremes and around zero
    function automatic int pick_coord(int flavor);
        int picks[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        case (flavor)
            0: return $signed(16'($urandom));
            1: return $urandom_range(0, 16) - 8;
            default: return picks[$urandom_range(0, 6)];
        endcase
    endfunction

    task automatic add_random_pair();
        int c[8];
        int r, flavor, px, py, dx, dy;
        r = $urandom_range(0, 99);
        flavor = (r < 30) ? 0 : ((r < 60) ? 1 : 2);
        foreach (c[k]) c[k] = pick_coord(flavor);
        if (r >= 75 && r < 90) begin
            // shared endpoint: copy one end of A onto one end of B
            r = $urandom_range(0, 3);
            c[4 + 2 * (r % 2)]     = c[2 * (r / 2)];
            c[4 + 2 * (r % 2) + 1] = c[2 * (r / 2) + 1];
        end else if (r >= 90) begin
            // all four points on one line
            px = $urandom_range(0, 2000) - 1000;
            py = $urandom_range(0, 2000) - 1000;
            dx = $urandom_range(0, 100) - 50;
            dy = $urandom_range(0, 100) - 50;
            for (int k = 0; k < 4; k++) begin
                r = $urandom_range(0, 40) - 20;
                c[2 * k]     = px + r * dx;
                c[2 * k + 1] = py + r * dy;
            end
        end
        add_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endtask

    // Driver: offer pending pairs, hold each beat until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            tx_busy = i_valid;
            if (i_valid && o_ready) begin
                hit_expected_q.push_back(seg_pair_hit(cur_pair));
                pairs_sent <= pairs_sent + 1;
                tx_busy = 1'b0;
            end
            if (!tx_busy) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_pairs.size() > 0) begin
                    cur_pair = pending_pairs.pop_front();
                    i_a_start_x <= cur_pair.a_sx;
                    i_a_start_y <= cur_pair.a_sy;
                    i_a_end_x   <= cur_pair.a_ex;
                    i_a_end_y   <= cur_pair.a_ey;
                    i_b_start_x <= cur_pair.b_sx;
                    i_b_start_y <= cur_pair.b_sy;
                    i_b_end_x   <= cur_pair.b_ex;
                    i_b_end_y   <= cur_pair.b_ey;
                    i_valid     <= 1'b1;
                    tx_gap_left = draw_gap(tx_quiet_left);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold once the stream is under way, so the pipeline backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (rx_hold) begin
            if (hold_left == 0) begin
                rx_hold   <= 1'b0;
                hold_done <= 1'b1;
            end else begin
                hold_left <= hold_left - 1;
            end
        end else if (!hold_done && pairs_sent >= HOLD_AFTER) begin
            rx_hold   <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // Monitor: random ready, compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (hit_expected_q.size() == 0) begin
                    if (mismatch_cnt < REPORT_MAX)
                        $display("ERROR: result beat with none expected, intersects=%b",
                                 o_intersects);
                    mismatch_cnt++;
                end else if (o_intersects !== hit_expected_q[0]) begin
                    if (mismatch_cnt < REPORT_MAX)
                        $display("ERROR: intersects expected %b, got %b",
                                 hit_expected_q[0], o_intersects);
                    mismatch_cnt++;
                    void'(hit_expected_q.pop_front());
                end else begin
                    void'(hit_expected_q.pop_front());
                end
            end
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !rx_hold;
                rx_stall_left = draw_gap(rx_quiet_left);
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // crossing diagonals, full-range diagonals
        add_pair(-10, -10, 10, 10, -10, 10, 10, -10);
        add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        // disjoint boxes, boxes touching only at a corner
        add_pair(0, 0, 5, 5, 20, 20, 30, 25);
        add_pair(0, 0, 5, 5, 5, 0, 9, -4);
        // boxes overlap but B stays on one side of A
        add_pair(0, 0, 10, 10, 6, 0, 10, 3);
        // touching endpoints, endpoint on the other segment's interior
        add_pair(0, 0, 5, 5, 5, 5, 10, 0);
        add_pair(0, 0, 10, 0, 5, 0, 5, 7);
        // collinear: overlapping, end to end, with a gap
        add_pair(0, 0, 10, 0, 5, 0, 15, 0);
        add_pair(0, 0, 4, 4, 4, 4, 9, 9);
        add_pair(0, 0, 4, 4, 5, 5, 9, 9);
        add_pair(-3, 6, 3, -6, 1, -2, 2, -4);
        // point segments: equal points, point on a segment, point off it
        add_pair(7, -7, 7, -7, 7, -7, 7, -7);
        add_pair(2, 2, 2, 2, 0, 0, 4, 4);
        add_pair(2, 3, 2, 3, 0, 0, 4, 4);
        // all-minimum and all-maximum coordinates
        add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        // nearly parallel long segments at the extremes
        add_pair(-32768, -32768, 32767, 32767, -32768, -32767, 32766, 32767);
        add_pair(-32768, -32767, 32767, 32767, -32767, -32768, 32767, 32766);
        add_pair(32767, -32768, -32768, 32767, 32767, -32767, -32767, 32767);
        // parallel vertical segments, crossing with swapped end order
        add_pair(3, -100, 3, 100, 4, -100, 4, 100);
        add_pair(10, 10, -10, -10, 10, -10, -10, 10);
        // one bit set per field, then every bit set
        add_pair(1, 2, 4, 8, 16, 32, 64, 128);
        add_pair(-1, -1, -1, -1, -1, -1, -1, -1);

        repeat (RANDOM_PAIRS) add_random_pair();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || i_valid) @(posedge i_clk);
        while (hit_expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && hit_expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sit_pkg.sv
hw/rtl/sit_front.sv
hw/rtl/sit_prod.sv
hw/rtl/sit_sign.sv
hw/rtl/sit_decide.sv
hw/rtl/segment_intersection_test.sv
tb/segment_intersection_test_tb.sv
